>>> design/irplr_pkg.sv
// ----------------------------------------------------------------------------
// irplr_pkg
// shared types and defaults for the ir pulse learn / replay block
// ----------------------------------------------------------------------------
package irplr_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int TIME_WIDTH_DEF  = 16;

	// command codes carried on the input channel
	typedef enum logic [1:0] {
		CMD_ARM  = 2'd0,
		CMD_EDGE = 2'd1,
		CMD_PLAY = 2'd2
	} cmd_t;

	// strobes from the controller to the duration store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

>>> design/ir_pulse_learn_replay_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_learn_replay_top
// learns an ir pulse train as edge intervals and replays it segment by segment
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// -------   ---------  --------------------  ---------------------------------
// input     in         in_valid / in_ready   cmd, duration, overrun
// result    out        out_valid / out_ready frame_ready, capture_active,
//                                            frame_length, play_duration,
//                                            play_valid, carrier_on, play_done
//
// - one transfer in, one result out; out_valid is registered and rises in
//   the cycle after the input transfer, with the registered duration memory read
// - a new input transfer is taken every cycle while the result register is
//   empty or being drained in the same cycle, so one item per cycle sustained
// - a stalled result holds the input side off; nothing is lost or repeated
// - reset clears the counters, maxima and flags; the duration memory is
//   not cleared and entries are only read after they were written
//
module ir_pulse_learn_replay_top import irplr_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [TIME_WIDTH-1:0]        duration,
	input  logic                         overrun,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         frame_ready,
	output logic                         capture_active,
	output logic [$clog2(STORE_DEPTH):0] frame_length,
	output logic [TIME_WIDTH-1:0]        play_duration,
	output logic                         play_valid,
	output logic                         carrier_on,
	output logic                         play_done
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic                  out_valid_q;
	logic                  step;
	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [TIME_WIDTH-1:0] rd_data;

	// result register empty or emptied this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// state and decisions
	irplr_ctrl #(
		.STORE_DEPTH (STORE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.cmd            (cmd),
		.duration       (duration),
		.overrun        (overrun),
		.mem_ctl        (mem_ctl),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr),
		.frame_ready    (frame_ready),
		.capture_active (capture_active),
		.frame_length   (frame_length),
		.play_valid     (play_valid),
		.carrier_on     (carrier_on),
		.play_done      (play_done)
	);

	// captured intervals; read data doubles as the duration output register
	irplr_store #(
		.STORE_DEPTH (STORE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (duration),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// no segment this step: duration reads as zero
	assign play_duration = play_valid ? rd_data : '0;

endmodule

>>> design/irplr_store.sv
// ----------------------------------------------------------------------------
// irplr_store
// duration memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module irplr_store import irplr_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  mem_ctl_t                       ctl,
	input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
	input  logic [TIME_WIDTH-1:0]          wr_data,
	input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
	output logic [TIME_WIDTH-1:0]          rd_data
);

	logic [TIME_WIDTH-1:0] mem_q [STORE_DEPTH];
	logic [TIME_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/irplr_ctrl.sv
// ----------------------------------------------------------------------------
// irplr_ctrl
// capture and playback control: frame count, gap maxima, play index
// ----------------------------------------------------------------------------
module irplr_ctrl import irplr_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [1:0]                     cmd,
	input  logic [TIME_WIDTH-1:0]          duration,
	input  logic                           overrun,
	output mem_ctl_t                       mem_ctl,
	output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
	output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
	output logic                           frame_ready,
	output logic                           capture_active,
	output logic [$clog2(STORE_DEPTH):0]   frame_length,
	output logic                           play_valid,
	output logic                           carrier_on,
	output logic                           play_done
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         play_idx_q, play_idx_d;
	logic [TIME_WIDTH-1:0] high_q, high_d;
	logic [TIME_WIDTH-1:0] low_q, low_d;
	logic                  expect_rising_q, expect_rising_d;
	logic                  capturing_q, capturing_d;
	logic                  frame_ready_q, frame_ready_d;
	logic                  play_valid_q, play_valid_d;
	logic                  carrier_on_q, carrier_on_d;
	logic                  play_done_q, play_done_d;

	logic                  room;
	logic                  have_first;
	logic [TIME_WIDTH-1:0] new_high;
	logic [TIME_WIDTH-1:0] new_low;
	logic                  gap_end;

	assign room       = count_q < DEPTH_C;
	assign have_first = count_q != '0;
	assign new_high   = (have_first && duration > high_q) ? duration : high_q;
	assign new_low    = (have_first && duration > low_q) ? duration : low_q;
	// high gap beyond twice the low gap
	assign gap_end    = {1'b0, new_high} > {low_q, 1'b0};

	assign wr_addr = count_q[AW-1:0];
	assign rd_addr = play_idx_q[AW-1:0];

	always_comb begin
		count_d         = count_q;
		play_idx_d      = play_idx_q;
		high_d          = high_q;
		low_d           = low_q;
		expect_rising_d = expect_rising_q;
		capturing_d     = capturing_q;
		frame_ready_d   = frame_ready_q;
		play_valid_d    = play_valid_q;
		carrier_on_d    = carrier_on_q;
		play_done_d     = play_done_q;
		mem_ctl         = '0;
		if (step) begin
			frame_ready_d = 1'b0;
			play_valid_d  = 1'b0;
			carrier_on_d  = 1'b0;
			play_done_d   = 1'b0;
			case (cmd_t'(cmd))
				CMD_ARM: begin
					count_d         = '0;
					high_d          = '0;
					low_d           = '0;
					expect_rising_d = 1'b0;
					capturing_d     = 1'b1;
				end
				CMD_EDGE: begin
					if (capturing_q) begin
						mem_ctl.wr_en   = room;
						expect_rising_d = !expect_rising_q;
						if (!expect_rising_q && gap_end) begin
							// gap rule ends the frame, edge not counted
							capturing_d   = 1'b0;
							high_d        = '0;
							low_d         = '0;
							frame_ready_d = 1'b1;
						end else begin
							if (!expect_rising_q) begin
								high_d = new_high;
							end else begin
								low_d = new_low;
							end
							if (room) begin
								count_d = count_q + ONE_C;
							end
							if (overrun) begin
								capturing_d   = 1'b0;
								high_d        = '0;
								low_d         = '0;
								frame_ready_d = 1'b1;
							end
						end
					end
				end
				CMD_PLAY: begin
					if (play_idx_q < count_q && play_idx_q < DEPTH_C) begin
						mem_ctl.rd_en = 1'b1;
						play_valid_d  = 1'b1;
						carrier_on_d  = play_idx_q[0];
						play_idx_d    = play_idx_q + ONE_C;
					end else begin
						play_idx_d  = ONE_C;
						play_done_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			play_idx_q      <= ONE_C;
			high_q          <= '0;
			low_q           <= '0;
			expect_rising_q <= 1'b0;
			capturing_q     <= 1'b0;
			frame_ready_q   <= 1'b0;
			play_valid_q    <= 1'b0;
			carrier_on_q    <= 1'b0;
			play_done_q     <= 1'b0;
		end else begin
			count_q         <= count_d;
			play_idx_q      <= play_idx_d;
			high_q          <= high_d;
			low_q           <= low_d;
			expect_rising_q <= expect_rising_d;
			capturing_q     <= capturing_d;
			frame_ready_q   <= frame_ready_d;
			play_valid_q    <= play_valid_d;
			carrier_on_q    <= carrier_on_d;
			play_done_q     <= play_done_d;
		end
	end

	assign frame_ready    = frame_ready_q;
	assign capture_active = capturing_q;
	assign frame_length   = count_q;
	assign play_valid     = play_valid_q;
	assign carrier_on     = carrier_on_q;
	assign play_done      = play_done_q;

endmodule

>>> design/irplr_checker.sv
// ----------------------------------------------------------------------------
// irplr_checker
// port-level checks for the ir pulse learn / replay block
// ----------------------------------------------------------------------------
module irplr_checker import irplr_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [1:0]                   cmd,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         frame_ready,
	input logic                         capture_active,
	input logic [$clog2(STORE_DEPTH):0] frame_length,
	input logic [TIME_WIDTH-1:0]        play_duration,
	input logic                         play_valid,
	input logic                         carrier_on,
	input logic                         play_done
);

	localparam logic [$clog2(STORE_DEPTH):0] DEPTH_C = ($clog2(STORE_DEPTH)+1)'(STORE_DEPTH);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(play_duration)
			&& $stable(play_valid) && $stable(frame_length))
		else $error("stalled result changed");

	// a segment and a done pulse never come together
	a_play_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(play_valid && play_done))
		else $error("play_valid with play_done");

	// carrier only for a segment that is played
	a_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carrier_on |-> play_valid)
		else $error("carrier_on without play_valid");

	// frame end stops capture and count never passes the store depth
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_ready || !capture_active) && frame_length <= DEPTH_C)
		else $error("frame end or length inconsistent");

	// arm always starts a capture with an empty frame
	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_ARM |=> out_valid && capture_active
			&& frame_length == '0)
		else $error("arm did not start capture");

endmodule

bind ir_pulse_learn_replay_top irplr_checker #(
	.STORE_DEPTH (STORE_DEPTH),
	.TIME_WIDTH  (TIME_WIDTH)
) u_irplr_checker (.*);

>>> tb/ir_pulse_learn_replay_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_learn_replay_top_test
// self-checking bench for the ir pulse learn / replay block: a queue-fed
// driver offers arm, edge and play commands, a predictor tracks the learned
// frame and replay pointer, and the monitor checks every result transfer
// ----------------------------------------------------------------------------
module ir_pulse_learn_replay_top_test;
	import irplr_pkg::*;

	localparam int DEPTH  = STORE_DEPTH_DEF;
	localparam int TIME_W = TIME_WIDTH_DEF;
	localparam int LEN_W  = $clog2(DEPTH) + 1;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int GAP_MAX         = 30;    // longest sender idle run per item
	localparam int HOLD_CYCLES     = 300;   // long result-side hold-off
	localparam int DRAIN_CYCLES    = 20;    // quiet time after the last result
	localparam int WATCHDOG_CYCLES = 4000;  // cycles without any transfer
	localparam int MAX_PRINTED     = 200;

	// the package names three commands; the fourth code is unused
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic              frame_ready;
		logic              capture_active;
		logic [LEN_W-1:0]  frame_length;
		logic [TIME_W-1:0] play_duration;
		logic              play_valid;
		logic              carrier_on;
		logic              play_done;
	} ir_result_t;

	typedef struct {
		logic [1:0]        op;
		logic [TIME_W-1:0] dur;
		logic              ovr;
		int unsigned       gap;    // idle cycles before this item is offered
	} ir_event_t;

	// ------------------------------------------------------------------
	// clock, reset and block ports, the bench-driven ones known from time zero
	// ------------------------------------------------------------------
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd      = CMD_ARM;
	logic [TIME_W-1:0] duration = '0;
	logic              overrun  = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              frame_ready;
	logic              capture_active;
	logic [LEN_W-1:0]  frame_length;
	logic [TIME_W-1:0] play_duration;
	logic              play_valid;
	logic              carrier_on;
	logic              play_done;

	always #(CLK_PERIOD / 2) clk = ~clk;

	ir_pulse_learn_replay_top #(
		.STORE_DEPTH(DEPTH),
		.TIME_WIDTH (TIME_W)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.duration      (duration),
		.overrun       (overrun),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ready   (frame_ready),
		.capture_active(capture_active),
		.frame_length  (frame_length),
		.play_duration (play_duration),
		.play_valid    (play_valid),
		.carrier_on    (carrier_on),
		.play_done     (play_done)
	);

	// ------------------------------------------------------------------
	// bench bookkeeping
	// ------------------------------------------------------------------
	ir_event_t   pending_events[$];     // filled by the stimulus, drained by the driver
	ir_result_t  expected_results[$];   // one entry per accepted input transfer
	int unsigned queued_items   = 0;
	int unsigned accepted_items = 0;
	int unsigned mismatches     = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned tx_idle_pct    = 0;
	int unsigned rx_stall_pct   = 0;
	bit          hold_request   = 1'b0;
	bit          in_taken       = 1'b0; // input transfer seen at the last rising edge

	// ------------------------------------------------------------------
	// predictor state: learned frame, capture tracking and replay pointer
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] learned_dur[DEPTH];
	logic [LEN_W-1:0]  learned_count = '0;
	logic [TIME_W-1:0] peak_high     = '0;
	logic [TIME_W-1:0] peak_low      = '0;
	logic              await_rise    = 1'b0;
	logic              armed         = 1'b0;
	logic [LEN_W-1:0]  replay_idx    = LEN_W'(1);

	// advance the predictor by one accepted command and return its result
	function automatic ir_result_t predict_ir_step(input logic [1:0] op,
		input logic [TIME_W-1:0] t, input logic ovr);
		ir_result_t r;
		logic       room;
		logic       frame_end;
		r = '0;
		frame_end = 1'b0;
		case (op)
			CMD_ARM: begin
				// replay pointer survives an arm
				learned_count = '0;
				peak_high     = '0;
				peak_low      = '0;
				await_rise    = 1'b0;
				armed         = 1'b1;
			end
			CMD_EDGE: begin
				if (armed) begin
					room = learned_count < DEPTH;
					if (room)
						learned_dur[learned_count] = t;
					if (!await_rise) begin
						// high gap; the first edge of a frame leaves both peaks alone
						await_rise = 1'b1;
						if (learned_count != 0 && t > peak_high)
							peak_high = t;
						// gap rule: written but not counted, overrun not looked at
						if ({1'b0, peak_high} > {peak_low, 1'b0})
							frame_end = 1'b1;
					end else begin
						await_rise = 1'b0;
						if (learned_count != 0 && t > peak_low)
							peak_low = t;
					end
					if (!frame_end) begin
						// a full store holds its count, peaks still follow the edge
						if (room)
							learned_count = learned_count + 1'b1;
						if (ovr)
							frame_end = 1'b1;
					end
					if (frame_end) begin
						// polarity is kept across the frame end
						armed         = 1'b0;
						peak_high     = '0;
						peak_low      = '0;
						r.frame_ready = 1'b1;
					end
				end
			end
			CMD_PLAY: begin
				if (replay_idx < learned_count && replay_idx < DEPTH) begin
					r.play_duration = learned_dur[replay_idx];
					r.play_valid    = 1'b1;
					r.carrier_on    = replay_idx[0];
					replay_idx      = replay_idx + 1'b1;
				end else begin
					replay_idx  = LEN_W'(1);
					r.play_done = 1'b1;
				end
			end
			default: ;
		endcase
		r.capture_active = armed;
		r.frame_length   = learned_count;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued commands at the falling edge, holding each one
	// until its transfer, with the idle gap chosen when it was queued
	// ------------------------------------------------------------------
	ir_event_t cur_event;
	bit        event_loaded = 1'b0;

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (!event_loaded && pending_events.size() != 0) begin
				cur_event    = pending_events.pop_front();
				event_loaded = 1'b1;
			end
			if (event_loaded && cur_event.gap == 0) begin
				in_valid     <= 1'b1;
				cmd          <= cur_event.op;
				duration     <= cur_event.dur;
				overrun      <= cur_event.ovr;
				event_loaded = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (event_loaded)
					cur_event.gap--;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off on request that is
	// counted here so the sender keeps pushing into a stalled block
	// ------------------------------------------------------------------
	int unsigned hold_left = 0;

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// monitor: at each rising edge check a result transfer against the
	// oldest expectation first, then predict the input transfer of the
	// same edge, whose result can only show up later
	// ------------------------------------------------------------------
	ir_result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with no command outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("frame_ready",    32'(frame_ready),
						32'(want.frame_ready));
					check_field("capture_active", 32'(capture_active),
						32'(want.capture_active));
					check_field("frame_length",   32'(frame_length),
						32'(want.frame_length));
					check_field("play_duration",  32'(play_duration),
						32'(want.play_duration));
					check_field("play_valid",     32'(play_valid),
						32'(want.play_valid));
					check_field("carrier_on",     32'(carrier_on),
						32'(want.carrier_on));
					check_field("play_done",      32'(play_done),
						32'(want.play_done));
				end
			end
			if (in_taken) begin
				expected_results.push_back(predict_ir_step(cmd, duration, overrun));
				accepted_items++;
			end
			// watchdog on handshake progress
			if (in_taken || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("ir_pulse_learn_replay_top: mismatch");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(input logic [1:0] op, input logic [TIME_W-1:0] t,
		input logic ovr);
		ir_event_t ev;
		ev.op  = op;
		ev.dur = t;
		ev.ovr = ovr;
		ev.gap = 0;
		while (ev.gap < GAP_MAX && $urandom_range(99) < tx_idle_pct)
			ev.gap++;
		pending_events.push_back(ev);
		queued_items++;
	endtask

	// arm plus a plausible pulse train: low gaps near a base value, high gaps
	// no longer than twice that, ending open, on the gap rule or on overrun
	task automatic queue_frame(input int unsigned n_edges, input bit end_on_overrun);
		int unsigned base;
		int unsigned stop_kind;
		int unsigned t;
		int unsigned n_plays;
		base      = $urandom_range(1, 26000);
		stop_kind = end_on_overrun ? 2 : $urandom_range(0, 2);
		// the gap rule needs a closing high gap after at least one low gap
		if (stop_kind == 1 && (n_edges < 3 || n_edges % 2 == 0))
			stop_kind = 2;
		push_item(CMD_ARM, TIME_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
		for (int unsigned k = 0; k < n_edges; k++) begin
			if (k % 2 == 1)
				t = base + $urandom_range(0, base / 4);
			else if (k == n_edges - 1 && stop_kind == 1)
				t = 2 * (base + base / 4) + 1 + $urandom_range(0, 400);
			else
				t = $urandom_range(0, 2 * base);
			push_item(CMD_EDGE, TIME_W'(t), k == n_edges - 1 && stop_kind == 2);
			// occasional replay tick while the frame is still being learned
			if ($urandom_range(7) == 0)
				push_item(CMD_PLAY, TIME_W'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
		end
		n_plays = $urandom_range(0, n_edges + 2);
		repeat (n_plays)
			push_item(CMD_PLAY, TIME_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed frames, the rest raw commands of any code
	task automatic queue_traffic(input int unsigned goal);
		while (queued_items < goal) begin
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(9) == 0)
					queue_frame($urandom_range(13, 40), 1'b0);
				else
					queue_frame($urandom_range(1, 12), 1'b0);
			end else begin
				repeat ($urandom_range(1, 6))
					push_item(2'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	// sender side pause until every queued command has its result
	task automatic wait_settled();
		while (accepted_items != queued_items || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	int unsigned tx_plan[4]   = '{0, 51, 0, 14};
	int unsigned rx_plan[4]   = '{0, 0, 51, 14};
	int unsigned item_plan[4] = '{100, 180, 180, 180};

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty replay, ignored edge, unused code, first edge
		// not touching the peaks, gap-rule end with a zero low gap,
		// overrun on the very first edge, replay during capture,
		// full-scale intervals and replay past the end
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_EDGE,   16'hFFFF, 1'b1);
		push_item(CMD_UNUSED, 16'h5A5A, 1'b0);
		push_item(CMD_ARM,    16'h0000, 1'b0);
		push_item(CMD_EDGE,   16'hFFFF, 1'b0);
		push_item(CMD_EDGE,   16'h0000, 1'b0);
		push_item(CMD_EDGE,   16'h0001, 1'b1);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_ARM,    16'hFFFF, 1'b1);
		push_item(CMD_EDGE,   16'd100,  1'b1);
		push_item(CMD_EDGE,   16'd200,  1'b0);
		push_item(CMD_ARM,    16'h0000, 1'b0);
		push_item(CMD_EDGE,   16'd40000, 1'b0);
		push_item(CMD_EDGE,   16'd30000, 1'b0);
		push_item(CMD_PLAY,   16'hFFFF, 1'b1);
		push_item(CMD_EDGE,   16'd60000, 1'b0);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_EDGE,   16'hFFFF, 1'b0);
		push_item(CMD_EDGE,   16'hFFFF, 1'b1);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_PLAY,   16'h0000, 1'b0);
		push_item(CMD_UNUSED, 16'hFFFF, 1'b1);
		push_item(CMD_ARM,    16'h0000, 1'b0);
		wait_settled();

		// random phases with different idling on each side
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = tx_plan[p];
			rx_stall_pct = rx_plan[p];
			if (p == 0) begin
				// overfill the store, then replay the whole frame and wrap
				queue_frame(DEPTH + 6, 1'b1);
				repeat (DEPTH + 4)
					push_item(CMD_PLAY, TIME_W'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
			end
			if (p == 2)
				hold_request = 1'b1;  // block must back up and stall its input
			queue_traffic(queued_items + item_plan[p]);
			wait_settled();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ir_pulse_learn_replay_top: match");
		else
			$display("ir_pulse_learn_replay_top: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/irplr_pkg.sv
design/irplr_store.sv
design/irplr_ctrl.sv
design/ir_pulse_learn_replay_top.sv
design/irplr_checker.sv
tb/ir_pulse_learn_replay_top_test.sv
